FILE: sv/htdec_pkg.sv
// Shared constants and helpers for the Huffman tree header decoder.
package htdec_pkg;

  localparam int MAX_NODES_DEF   = 512;
  localparam int STACK_DEPTH_DEF = 256;

  localparam logic [7:0]  SYM_INTERNAL = 8'h2A;
  localparam logic [7:0]  SYM_ESCAPE   = 8'h5C;
  localparam int          COUNT_W      = 24;
  localparam logic [23:0] COUNT_MAX    = 24'hFF_FFFF;
  localparam int          LEN_W        = 13;
  localparam int          TRASH_W      = 3;

  localparam logic BIT_ORDER_MSB_FIRST = 1'b0;

  // Picks code bit number idx of a data byte in the configured order.
  function automatic logic sel_bit(input logic [7:0] b, input logic [2:0] idx,
                                   input logic order);
    logic res;
    if (order == BIT_ORDER_MSB_FIRST) begin
      res = b[3'd7 - idx];
    end else begin
      res = b[idx];
    end
    return res;
  endfunction

endpackage

FILE: sv/htdec_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module htdec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/huffman_tree_header_decoder_core.sv
// Huffman decoder core: reads a preorder tree header, then decodes data bytes into symbols.
//
// The block takes a compressed file one byte per input transfer. Two header bytes give a
// 3-bit trash count and a 13-bit tree length, the tree follows in preorder, and every later
// byte is decoded bit by bit into symbols, one output transfer per symbol. A leaf that
// leaves a right child pending has it popped from the stack memory before the next tree
// byte is taken. A data byte is accepted, the walk starts with the first node-table read,
// the node memory is then read once per code bit because its single read port sets the
// pace, and the byte's final symbol is released last with its end-of-run mark. A stalled
// result stream holds up the walk. A tree that is a single leaf needs no reads, and it
// emits its symbol once per bit. Malformed or truncated headers give a single result with
// status set, after which bytes are dropped until the last byte of the file. The node and
// stack memories need no clearing after reset.
module huffman_tree_header_decoder_core #(
  parameter int MAX_NODES   = htdec_pkg::MAX_NODES_DEF,
  parameter int STACK_DEPTH = htdec_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: bit 0 selects the code bit order (0 most significant first).
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte[7:0]
  input  logic        in_tlast,   // last_byte
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_byte[7:0], decoded_count[31:8]
  output logic        out_tlast,  // last_of_run
  output logic [1:0]  out_tuser   // end_of_stream[0], status[1]
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int CW  = htdec_pkg::COUNT_W;
  localparam int LW  = htdec_pkg::LEN_W;
  localparam int TW  = htdec_pkg::TRASH_W;

  // One node-table entry. Children are only meaningful for internal nodes.
  typedef struct packed {
    logic          leaf;
    logic [7:0]    sym;
    logic [NW-1:0] right;
    logic [NW-1:0] left;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [2:0] {
    S_HDR0, S_HDR1, S_TREE, S_POP, S_DWAIT, S_DBIT, S_DFLUSH, S_ERR
  } state_t;

  state_t          state_r, state_nxt;
  logic            bit_order_r, bit_order_nxt;
  logic [TW-1:0]   trash_r, trash_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [LW-1:0]   hc_r, hc_nxt;
  logic [NW:0]     free_r, free_nxt;
  logic [NW-1:0]   walk_r, walk_nxt;
  logic [SW:0]     top_r, top_nxt;
  logic            esc_r, esc_nxt;
  logic [CW-1:0]   total_r, total_nxt;
  node_t           root_r, root_nxt;
  node_t           cur_r, cur_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            last_r, last_nxt;
  logic [2:0]      bit_idx_r, bit_idx_nxt;
  logic [3:0]      nbits_r, nbits_nxt;
  logic            resp_v_r, resp_v_nxt;
  logic            hold_v_r, hold_v_nxt;
  logic [7:0]      hold_sym_r, hold_sym_nxt;
  logic [CW-1:0]   hold_cnt_r, hold_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_data_r, out_data_nxt;
  logic            out_last_r, out_last_nxt;
  logic [1:0]      out_user_r, out_user_nxt;

  // Memory ports.
  logic            node_we, node_re;
  logic [NW-1:0]   node_waddr, node_raddr;
  node_t           node_wdata;
  logic [NODE_W-1:0] node_rdata_raw;
  node_t           node_rdata;
  logic            stk_we, stk_re;
  logic [SW-1:0]   stk_waddr, stk_raddr;
  logic [NW-1:0]   stk_wdata, stk_rdata;

  // Working signals.
  logic            in_acc, can_push;
  logic            push, push_last, push_eos, push_err;
  logic [7:0]      push_byte;
  logic [CW-1:0]   push_cnt, cnt_inc;
  logic [LW-1:0]   hc_inc, len_cat;
  logic            tree_leaf, terr, tdone;
  node_t           leaf_rec;
  logic            cur_bit, next_bit, more, produce, go, step;
  logic [7:0]      sym_prod;
  node_t           next_cur;

  assign in_tready = ((state_r == S_HDR0 || state_r == S_HDR1 || state_r == S_TREE ||
                       state_r == S_ERR) && !out_valid_r) || (state_r == S_DWAIT);
  assign in_acc    = in_tvalid && in_tready;
  assign can_push  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  assign node_rdata = node_t'(node_rdata_raw);
  assign cnt_inc    = (total_r == htdec_pkg::COUNT_MAX) ? total_r : total_r + 1'b1;
  assign hc_inc     = hc_r + 1'b1;
  assign len_cat    = {len_r[LW-1:8], in_tdata};

  assign cur_bit  = htdec_pkg::sel_bit(byte_r, bit_idx_r, bit_order_r);
  assign next_bit = htdec_pkg::sel_bit(byte_r, bit_idx_r + 3'd1, bit_order_r);
  assign more     = ({1'b0, bit_idx_r} + 4'd1) < nbits_r;

  always_comb begin
    state_nxt     = state_r;
    bit_order_nxt = bit_order_r;
    trash_nxt     = trash_r;
    len_nxt       = len_r;
    hc_nxt        = hc_r;
    free_nxt      = free_r;
    walk_nxt      = walk_r;
    top_nxt       = top_r;
    esc_nxt       = esc_r;
    total_nxt     = total_r;
    root_nxt      = root_r;
    cur_nxt       = cur_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    bit_idx_nxt   = bit_idx_r;
    nbits_nxt     = nbits_r;
    resp_v_nxt    = resp_v_r;
    hold_v_nxt    = hold_v_r;
    hold_sym_nxt  = hold_sym_r;
    hold_cnt_nxt  = hold_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;

    node_we    = 1'b0;
    node_waddr = walk_r;
    node_wdata = '0;
    node_re    = 1'b0;
    node_raddr = cur_r.left;
    stk_we     = 1'b0;
    stk_waddr  = top_r[SW-1:0];
    stk_wdata  = free_r[NW-1:0] + 1'b1;
    stk_re     = 1'b0;
    stk_raddr  = top_r[SW-1:0] - 1'b1;

    push      = 1'b0;
    push_byte = '0;
    push_last = 1'b1;
    push_eos  = 1'b0;
    push_err  = 1'b1;
    push_cnt  = total_r;

    tree_leaf = 1'b0;
    terr      = 1'b0;
    tdone     = 1'b0;
    leaf_rec  = '{leaf: 1'b1, sym: in_tdata, right: '0, left: '0};
    produce   = 1'b0;
    go        = 1'b1;
    step      = 1'b0;
    sym_prod  = root_r.sym;
    next_cur  = root_r;

    if (cfg_wr_en) begin
      bit_order_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_HDR0: begin
        if (in_acc) begin
          trash_nxt = in_tdata[7:5];
          len_nxt   = {in_tdata[4:0], 8'h00};
          if (in_tlast) begin
            push      = 1'b1;
            total_nxt = '0;
          end else begin
            state_nxt = S_HDR1;
          end
        end
      end

      S_HDR1: begin
        if (in_acc) begin
          len_nxt = len_cat;
          if (len_cat == '0 || in_tlast) begin
            push      = 1'b1;
            state_nxt = in_tlast ? S_HDR0 : S_ERR;
            if (in_tlast) begin
              total_nxt = '0;
            end
          end else begin
            hc_nxt    = '0;
            free_nxt  = (NW + 1)'(1);
            walk_nxt  = '0;
            top_nxt   = '0;
            esc_nxt   = 1'b0;
            state_nxt = S_TREE;
          end
        end
      end

      S_TREE: begin
        if (in_acc) begin
          hc_nxt = hc_inc;
          if (esc_r) begin
            esc_nxt   = 1'b0;
            tree_leaf = 1'b1;
          end else if (in_tdata == htdec_pkg::SYM_INTERNAL) begin
            if (({1'b0, free_r} + (NW + 2)'(2)) > (NW + 2)'(MAX_NODES) ||
                top_r >= (SW + 1)'(STACK_DEPTH)) begin
              terr = 1'b1;
            end else begin
              node_we    = 1'b1;
              node_wdata = '{leaf: 1'b0, sym: in_tdata,
                             right: free_r[NW-1:0] + 1'b1, left: free_r[NW-1:0]};
              stk_we     = 1'b1;
              top_nxt    = top_r + 1'b1;
              walk_nxt   = free_r[NW-1:0];
              free_nxt   = free_r + (NW + 1)'(2);
            end
          end else if (in_tdata == htdec_pkg::SYM_ESCAPE) begin
            esc_nxt = 1'b1;
          end else begin
            tree_leaf = 1'b1;
          end

          if (tree_leaf) begin
            node_we    = 1'b1;
            node_wdata = leaf_rec;
            if (top_r == '0) begin
              tdone = 1'b1;
              if (hc_inc != len_r) begin
                terr = 1'b1;
              end else begin
                // Tree complete: the walk starts at the root for the first data bit.
                walk_nxt   = '0;
                cur_nxt    = (walk_r == '0) ? leaf_rec : root_r;
                resp_v_nxt = 1'b0;
                state_nxt  = in_tlast ? S_HDR0 : S_DWAIT;
              end
            end else begin
              top_nxt   = top_r - 1'b1;
              stk_re    = 1'b1;
              state_nxt = S_POP;
            end
          end

          if (!tdone && !terr && (hc_inc >= len_r || in_tlast)) begin
            terr = 1'b1;
          end

          if (terr) begin
            push      = 1'b1;
            state_nxt = in_tlast ? S_HDR0 : S_ERR;
            if (in_tlast) begin
              total_nxt = '0;
            end
          end
        end
      end

      S_POP: begin
        walk_nxt  = stk_rdata;
        state_nxt = S_TREE;
      end

      S_DWAIT: begin
        if (in_acc) begin
          byte_nxt    = in_tdata;
          last_nxt    = in_tlast;
          bit_idx_nxt = '0;
          nbits_nxt   = in_tlast ? 4'd8 - {1'b0, trash_r} : 4'd8;
          state_nxt   = S_DBIT;
        end
      end

      S_DBIT: begin
        if (root_r.leaf) begin
          // A one-leaf tree emits the root symbol for every bit.
          produce = 1'b1;
          step    = 1'b1;
        end else if (!resp_v_r) begin
          node_re    = 1'b1;
          node_raddr = cur_bit ? cur_r.right : cur_r.left;
          resp_v_nxt = 1'b1;
        end else begin
          step = 1'b1;
          if (node_rdata.leaf) begin
            produce  = 1'b1;
            sym_prod = node_rdata.sym;
          end else begin
            next_cur = node_rdata;
          end
        end

        // The previous symbol can only leave once this one replaces it in the hold stage.
        go = !(produce && hold_v_r && !can_push);

        if (go && step) begin
          if (produce && hold_v_r) begin
            push      = 1'b1;
            push_err  = 1'b0;
            push_last = 1'b0;
            push_byte = hold_sym_r;
            push_cnt  = hold_cnt_r;
          end
          if (produce) begin
            hold_v_nxt   = 1'b1;
            hold_sym_nxt = sym_prod;
            hold_cnt_nxt = cnt_inc;
            total_nxt    = cnt_inc;
          end
          cur_nxt = next_cur;
          if (more) begin
            bit_idx_nxt = bit_idx_r + 3'd1;
            if (!root_r.leaf) begin
              node_re    = 1'b1;
              node_raddr = next_bit ? next_cur.right : next_cur.left;
            end
          end else begin
            resp_v_nxt = 1'b0;
            state_nxt  = S_DFLUSH;
          end
        end
      end

      S_DFLUSH: begin
        if (!hold_v_r || can_push) begin
          if (hold_v_r) begin
            push       = 1'b1;
            push_err   = 1'b0;
            push_last  = 1'b1;
            push_eos   = last_r;
            push_byte  = hold_sym_r;
            push_cnt   = hold_cnt_r;
            hold_v_nxt = 1'b0;
          end
          if (last_r) begin
            total_nxt = '0;
            state_nxt = S_HDR0;
          end else begin
            state_nxt = S_DWAIT;
          end
        end
      end

      S_ERR: begin
        if (in_acc && in_tlast) begin
          total_nxt = '0;
          state_nxt = S_HDR0;
        end
      end

      default: begin
        state_nxt = S_HDR0;
      end
    endcase

    if (node_we && node_waddr == '0) begin
      root_nxt = node_wdata;
    end

    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {push_cnt, push_byte};
      out_last_nxt  = push_last;
      out_user_nxt  = {push_err, push_eos};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_HDR0;
      bit_order_r <= htdec_pkg::BIT_ORDER_MSB_FIRST;
      trash_r     <= '0;
      len_r       <= '0;
      hc_r        <= '0;
      free_r      <= '0;
      walk_r      <= '0;
      top_r       <= '0;
      esc_r       <= 1'b0;
      total_r     <= '0;
      resp_v_r    <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_order_r <= bit_order_nxt;
      trash_r     <= trash_nxt;
      len_r       <= len_nxt;
      hc_r        <= hc_nxt;
      free_r      <= free_nxt;
      walk_r      <= walk_nxt;
      top_r       <= top_nxt;
      esc_r       <= esc_nxt;
      total_r     <= total_nxt;
      resp_v_r    <= resp_v_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    root_r     <= root_nxt;
    cur_r      <= cur_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    bit_idx_r  <= bit_idx_nxt;
    nbits_r    <= nbits_nxt;
    hold_sym_r <= hold_sym_nxt;
    hold_cnt_r <= hold_cnt_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  // Node table: one entry per tree node, read once per code bit while decoding with a multi-node tree.
  htdec_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata_raw)
  );

  // Stack of right children still waiting to be filled while the tree is built.
  htdec_ram #(
    .WIDTH (NW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

FILE: tb/huffman_tree_header_decoder_core_tb.sv
// Self-checking testbench for the Huffman tree header decoder core: directed table, random files.
module huffman_tree_header_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The node table and stack sizes follow the block's default parameters.
  localparam int NODES = htdec_pkg::MAX_NODES_DEF;
  localparam int STACK = htdec_pkg::STACK_DEPTH_DEF;

  localparam logic BIT_ORDER_LSB_FIRST = 1'b1;
  localparam logic STATUS_SYMBOL       = 1'b0;
  localparam logic STATUS_BAD_HEADER   = 1'b1;

  // A data byte that yields no result still runs its walk inside the block, so the settle
  // wait after the last expected result is there for such a byte to finish.
  localparam int SETTLE_CYCLES   = 20;
  localparam int RX_HOLD_CYCLES  = 300;
  // Longest legal quiet stretch is the receiver hold-off; the limit is many times that.
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int ITEMS_PER_PHASE = 40;

  typedef enum logic [2:0] {ST_HDR0, ST_HDR1, ST_TREE, ST_DATA, ST_ERR} stage_t;
  typedef enum int {FILE_CLEAN, FILE_BAD_LENGTH, FILE_CUT_SHORT, FILE_NOISE} file_kind_t;

  // One result transfer, field by field.
  typedef struct packed {
    logic [7:0]  sym;
    logic        run_end;
    logic        eos;
    logic [23:0] count;
    logic        status;
  } result_t;

  // One row of the directed table. Where typed is set, the row carries its own expectation
  // (has_result says whether it yields one); otherwise the predictor decides.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    logic       has_result;
    result_t    res;
  } dir_row_t;

  localparam result_t NO_RESULT = '0;
  localparam result_t HDR_ERR   = '{8'h00, 1'b1, 1'b0, 24'd0, STATUS_BAD_HEADER};

  localparam dir_row_t DIRECTED [26] = '{
    // Truncated header: the very first byte already carries the end-of-file mark.
    '{8'h00, 1'b1, 1'b1, 1'b1, HDR_ERR},
    // Zero tree length, then a dropped byte that closes the broken file.
    '{8'hE0, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b1, 1'b1, HDR_ERR},
    '{8'h2A, 1'b1, 1'b1, 1'b0, NO_RESULT},
    // Single-leaf tree with seven trash bits: every data bit gives the root symbol.
    '{8'hE0, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h41, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b0, 1'b0, NO_RESULT},
    // Tree "* * A \* \\": codes 00 -> A, 01 -> '*', 1 -> '\', using both escapes.
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h07, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h2A, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h2A, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h41, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h5C, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h2A, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h5C, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h5C, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, 1'b0, 1'b0, NO_RESULT},
    // Tree ends early: a lone leaf against a declared length of three.
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h03, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h41, 1'b1, 1'b1, 1'b1, HDR_ERR},
    // Tree too long: a length of one used up by an internal node.
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{8'h2A, 1'b1, 1'b1, 1'b1, HDR_ERR}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;    // in_byte[7:0]
  logic        in_tlast = 1'b0;     // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // out_byte[7:0], decoded_count[31:8]
  logic        out_tlast;           // last_of_run
  logic [1:0]  out_tuser;           // end_of_stream[0], status[1]

  huffman_tree_header_decoder_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Decoder prediction. These variables mirror the block's state: the node table, the stack
  // of pending right children, the header fields and the walk position.
  // ---------------------------------------------------------------------------------------
  bit [8:0]  tree_left    [NODES];
  bit [8:0]  tree_right   [NODES];
  bit [7:0]  tree_sym     [NODES];
  bit        tree_is_leaf [NODES];
  bit [8:0]  right_stack  [STACK];
  bit [8:0]  sp;
  stage_t    stage = ST_HDR0;
  bit [2:0]  trash_q;
  bit [12:0] tree_len;
  bit [12:0] tree_seen;
  bit [9:0]  next_free;
  bit [8:0]  cursor;
  bit        esc_q;
  bit [23:0] sym_total;
  bit        order_q = htdec_pkg::BIT_ORDER_MSB_FIRST;

  result_t step_out[$];         // results of the byte just accepted
  result_t pending_results[$];  // results still to come out of the block

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int useful_items = 0;

  logic [7:0] tree_bytes[$];
  logic [7:0] file_bytes[$];
  bit         file_lasts[$];

  function automatic void start_file();
    stage = ST_HDR0;
    sp = '0;
    trash_q = '0;
    tree_len = '0;
    tree_seen = '0;
    next_free = '0;
    cursor = '0;
    esc_q = 1'b0;
    sym_total = '0;
  endfunction

  // A broken header gives one result with status set; the rest of the file is dropped.
  function automatic void flag_bad_header(input bit last);
    result_t r;
    r = '{8'h00, 1'b1, 1'b0, sym_total, STATUS_BAD_HEADER};
    step_out.push_back(r);
    if (last) start_file();
    else stage = ST_ERR;
  endfunction

  // One preorder tree byte: '*' opens an internal node and pushes its right child, a leaf
  // fills the current node and pops the next pending right child.
  function automatic void tree_step(input logic [7:0] b, input bit last);
    bit         leaf;
    logic [7:0] sym;
    leaf = 1'b0;
    sym = 8'h00;
    tree_seen++;
    if (esc_q) begin
      esc_q = 1'b0;
      leaf = 1'b1;
      sym = b;
    end else if (b == htdec_pkg::SYM_INTERNAL) begin
      if (int'(next_free) + 2 > NODES || int'(sp) >= STACK) begin
        flag_bad_header(last);
        return;
      end
      tree_left[cursor] = next_free[8:0];
      tree_right[cursor] = next_free[8:0] + 9'd1;
      tree_is_leaf[cursor] = 1'b0;
      tree_sym[cursor] = b;
      right_stack[sp] = next_free[8:0] + 9'd1;
      sp++;
      cursor = next_free[8:0];
      next_free += 10'd2;
    end else if (b == htdec_pkg::SYM_ESCAPE) begin
      esc_q = 1'b1;
    end else begin
      leaf = 1'b1;
      sym = b;
    end

    if (leaf) begin
      tree_sym[cursor] = sym;
      tree_is_leaf[cursor] = 1'b1;
      tree_left[cursor] = '0;
      tree_right[cursor] = '0;
      if (sp == 0) begin
        // The tree is complete; it must have used exactly the declared length.
        if (tree_seen != tree_len) begin
          flag_bad_header(last);
          return;
        end
        stage = ST_DATA;
        cursor = '0;
        if (last) start_file();
        return;
      end
      sp--;
      cursor = right_stack[sp];
    end
    if (tree_seen >= tree_len || last) flag_bad_header(last);
  endfunction

  // One data byte: walk the tree bit by bit, one symbol per leaf reached. The final byte of
  // a file skips its trash bits, and a code left unfinished there is dropped.
  function automatic void data_step(input logic [7:0] b, input bit last);
    int       nbits;
    int       n;
    bit       bv;
    bit [8:0] node;
    result_t  burst[8];
    nbits = last ? 8 - int'(trash_q) : 8;
    n = 0;
    for (int j = 0; j < nbits; j++) begin
      bv = (order_q == htdec_pkg::BIT_ORDER_MSB_FIRST) ? b[7 - j] : b[j];
      if (tree_is_leaf[0]) begin
        // A tree that is one leaf emits the root symbol for every bit.
        node = '0;
      end else begin
        node = bv ? tree_right[cursor] : tree_left[cursor];
        cursor = node;
        if (!tree_is_leaf[node]) continue;
      end
      cursor = '0;
      if (sym_total < htdec_pkg::COUNT_MAX) sym_total++;
      burst[n] = '{tree_sym[node], 1'b0, 1'b0, sym_total, STATUS_SYMBOL};
      n++;
    end
    if (n > 0) begin
      burst[n - 1].run_end = 1'b1;
      burst[n - 1].eos = last;
    end
    for (int k = 0; k < n; k++) step_out.push_back(burst[k]);
    if (last) start_file();
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input bit last);
    step_out.delete();
    case (stage)
      ST_HDR0: begin
        trash_q = b[7:5];
        tree_len = {b[4:0], 8'h00};
        stage = ST_HDR1;
        if (last) flag_bad_header(1'b1);
      end
      ST_HDR1: begin
        tree_len[7:0] = b;
        if (tree_len == 0 || last) begin
          flag_bad_header(last);
        end else begin
          tree_seen = '0;
          next_free = 10'd1;
          cursor = '0;
          sp = '0;
          esc_q = 1'b0;
          stage = ST_TREE;
        end
      end
      ST_TREE: tree_step(b, last);
      ST_DATA: data_step(b, last);
      default: if (last) start_file();
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus side. A byte is offered with a random number of idle cycles in front, held
  // until the transfer, and then run through the predictor in the same time step, before
  // the block can possibly answer.
  // ---------------------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                           input bit has_result, input result_t res);
    bit live;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    live = (stage != ST_ERR);
    decode_byte(b, last);
    if (live) useful_items++;
    if (typed) begin
      if (has_result) pending_results.push_back(res);
    end else begin
      foreach (step_out[k]) pending_results.push_back(step_out[k]);
    end
  endtask

  // Stop offering, wait for every expected result, then let a silent byte finish too.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle, so the new order applies to the next file.
  task automatic write_order(input logic order);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= order;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    order_q = order;
  endtask

  function automatic logic [7:0] leaf_symbol();
    int r;
    r = $urandom_range(99);
    if (r < 10) return htdec_pkg::SYM_INTERNAL;
    if (r < 20) return htdec_pkg::SYM_ESCAPE;
    return 8'($urandom_range(255));
  endfunction

  // Random preorder tree that is always well formed: open counts the child slots to fill.
  function automatic void build_tree(input int max_internal);
    int         open;
    int         internals;
    logic [7:0] s;
    open = 1;
    internals = 0;
    tree_bytes.delete();
    while (open > 0) begin
      if (internals < max_internal && $urandom_range(99) < 45) begin
        tree_bytes.push_back(htdec_pkg::SYM_INTERNAL);
        internals++;
        open++;
      end else begin
        s = leaf_symbol();
        // Bytes that would read as markers must be escaped; others sometimes are as well.
        if (s == htdec_pkg::SYM_INTERNAL || s == htdec_pkg::SYM_ESCAPE ||
            $urandom_range(9) == 0)
          tree_bytes.push_back(htdec_pkg::SYM_ESCAPE);
        tree_bytes.push_back(s);
        open--;
      end
    end
  endfunction

  function automatic void build_file(input file_kind_t kind, input int data_min,
                                     input int data_max);
    int        len;
    int        ndata;
    int        cut;
    bit [12:0] hdr_len;
    file_bytes.delete();
    file_lasts.delete();
    if (kind == FILE_NOISE) begin
      repeat ($urandom_range(1, 8)) begin
        file_bytes.push_back(8'($urandom_range(255)));
        file_lasts.push_back($urandom_range(4) == 0);
      end
    end else begin
      build_tree($urandom_range(0, 12));
      len = tree_bytes.size();
      if (kind == FILE_BAD_LENGTH) begin
        case ($urandom_range(2))
          0: len = len + 1;
          1: len = len - 1;
          default: len = $urandom_range(8191);
        endcase
      end
      hdr_len = 13'(len);
      file_bytes.push_back({3'($urandom_range(7)), hdr_len[12:8]});
      file_bytes.push_back(hdr_len[7:0]);
      foreach (tree_bytes[k]) file_bytes.push_back(tree_bytes[k]);
      ndata = $urandom_range(data_min, data_max);
      repeat (ndata) file_bytes.push_back(8'($urandom_range(255)));
      foreach (file_bytes[k]) file_lasts.push_back(1'b0);
      if (kind == FILE_CUT_SHORT) begin
        cut = $urandom_range(0, file_bytes.size() - 1);
        while (file_bytes.size() > cut + 1) begin
          void'(file_bytes.pop_back());
          void'(file_lasts.pop_back());
        end
      end
    end
    file_lasts[file_lasts.size() - 1] = 1'b1;
  endfunction

  // Sends the built file; a non-negative pause_at stalls the sender before that byte until
  // the block has delivered everything owed so far.
  task automatic send_file(input int pause_at);
    foreach (file_bytes[k]) begin
      if (k == pause_at) drain();
      send_byte(file_bytes[k], file_lasts[k], 1'b0, 1'b0, NO_RESULT);
    end
  endtask

  // Mostly well-formed files with random content, the rest broken or plain noise.
  task automatic random_files(input int items);
    int         start;
    int         r;
    file_kind_t kind;
    start = useful_items;
    while (useful_items - start < items) begin
      r = $urandom_range(99);
      if (r < 70) kind = FILE_CLEAN;
      else if (r < 80) kind = FILE_BAD_LENGTH;
      else if (r < 90) kind = FILE_CUT_SHORT;
      else kind = FILE_NOISE;
      build_file(kind, 0, 6);
      send_file(-1);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off on request, counted here.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_req && hold_left == 0) begin
      hold_left = RX_HOLD_CYCLES;
      rx_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Every result transfer is matched against the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[7:0], out_tlast, out_tuser[0], out_tdata[31:8], out_tuser[1]};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result at %0t: sym %02h run_end %b eos %b count %0d status %b",
                   $time, got.sym, got.run_end, got.eos, got.count, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got.sym !== want.sym || got.run_end !== want.run_end || got.eos !== want.eos ||
            got.count !== want.count || got.status !== want.status) begin
          errors++;
          if (errors <= 10) begin
            $display("result mismatch at %0t:", $time);
            $display("  expected sym %02h run_end %b eos %b count %0d status %b",
                     want.sym, want.run_end, want.eos, want.count, want.status);
            $display("  actual   sym %02h run_end %b eos %b count %0d status %b",
                     got.sym, got.run_end, got.eos, got.count, got.status);
          end
        end
      end
    end
  end

  // Watchdog: too many cycles without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    start_file();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First setting: sender idles rarely, receiver about half the time.
    tx_idle_pct = 11;
    rx_idle_pct = 53;
    write_order(htdec_pkg::BIT_ORDER_MSB_FIRST);
    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].b, DIRECTED[i].last, DIRECTED[i].typed,
                DIRECTED[i].has_result, DIRECTED[i].res);
    drain();

    write_order(BIT_ORDER_LSB_FIRST);
    random_files(ITEMS_PER_PHASE);
    drain();

    // Roles swapped.
    tx_idle_pct = 53;
    rx_idle_pct = 11;
    write_order(htdec_pkg::BIT_ORDER_MSB_FIRST);
    random_files(ITEMS_PER_PHASE);
    drain();

    // No idling. A long receiver hold-off while many data bytes are offered fills the block
    // and stalls its input; then a file where the sender waits for all results mid-data.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_order(BIT_ORDER_LSB_FIRST);
    rx_hold_req = 1'b1;
    build_file(FILE_CLEAN, 12, 12);
    send_file(-1);
    build_file(FILE_CLEAN, 4, 4);
    send_file(file_bytes.size() - 3);
    random_files(ITEMS_PER_PHASE);
    drain();

    errors += pending_results.size();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
